// File: hdl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants for the point/polytope penetration block.
// ----------------------------------------------------------------------------
package ppp_pkg;

	localparam int MaxFacesDef = 64;

	// distance pipeline stages from a face leaving the ring head to its distance being valid
	localparam int DistLat = 4;

	localparam int SumW = 51;
	localparam logic signed [SumW-1:0] RoundBias = 51'sd8192;

	localparam logic [1:0] ReqWrite    = 2'd0;
	localparam logic [1:0] ReqDepth    = 2'd1;
	localparam logic [1:0] ReqInMargin = 2'd2;
	localparam logic [1:0] ReqInZero   = 2'd3;

	localparam logic ReplyAck   = 1'b0;
	localparam logic ReplyQuery = 1'b1;

	localparam logic RegMargin = 1'b0;
	localparam logic RegCount  = 1'b1;

	localparam logic signed [31:0] MarginRst = 32'sd655;

	typedef enum logic {
		StIdle,
		StRun
	} state_t;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} face_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	typedef struct packed {
		logic we;
		logic shift;
	} cell_ctrl_t;

endpackage

// File: hdl/ppp_cell.sv
// ----------------------------------------------------------------------------
// ppp_cell
// One face slot of the face ring: loads on a face write, takes its
// neighbor's face on a shift.
// ----------------------------------------------------------------------------
module ppp_cell (
	input  logic               clk,
	input  ppp_pkg::cell_ctrl_t ctrl,
	input  ppp_pkg::face_t     wdata,
	input  ppp_pkg::face_t     nbr,
	output ppp_pkg::face_t     face
);
	import ppp_pkg::*;

	face_t face_q;

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			face_q <= wdata;
		end else if (ctrl.shift) begin
			face_q <= nbr;
		end
	end

	assign face = face_q;

endmodule

// File: hdl/ppp_dist.sv
// ----------------------------------------------------------------------------
// ppp_dist
// Signed face distance pipeline: dot(point - vertex, normal), rounded to
// Q16.16 and saturated to 32 bits.
// ----------------------------------------------------------------------------
module ppp_dist #(
	parameter int IdxW = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [IdxW-1:0]     in_tag,
	input  ppp_pkg::face_t      face,
	input  ppp_pkg::point_t     point,
	output logic                out_valid,
	output logic [IdxW-1:0]     out_tag,
	output logic signed [31:0]  distance
);
	import ppp_pkg::*;

	logic                   valid_s1, valid_s2, valid_s3, valid_s4;
	logic [IdxW-1:0]        tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [32:0]     dx_s1, dy_s1, dz_s1;
	logic signed [15:0]     nx_s1, ny_s1, nz_s1;
	logic signed [48:0]     px_s2, py_s2, pz_s2;
	logic signed [SumW-1:0] sum_s3;
	logic signed [31:0]     dist_s4;
	logic signed [36:0]     floor_q14;
	logic signed [31:0]     sat_dist;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// floor of (sum + 2^13) / 2^14 is an arithmetic shift of the biased sum
	assign floor_q14 = sum_s3[SumW-1:14];

	always_comb begin
		if (sum_s3[SumW-1:45] == {6{sum_s3[45]}}) begin
			sat_dist = floor_q14[31:0];
		end else if (sum_s3[SumW-1]) begin
			sat_dist = 32'sh8000_0000;
		end else begin
			sat_dist = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= in_tag;
		dx_s1  <= 33'(point.x) - 33'(face.vx);
		dy_s1  <= 33'(point.y) - 33'(face.vy);
		dz_s1  <= 33'(point.z) - 33'(face.vz);
		nx_s1  <= face.nx;
		ny_s1  <= face.ny;
		nz_s1  <= face.nz;

		tag_s2 <= tag_s1;
		px_s2  <= 49'(dx_s1) * 49'(nx_s1);
		py_s2  <= 49'(dy_s1) * 49'(ny_s1);
		pz_s2  <= 49'(dz_s1) * 49'(nz_s1);

		tag_s3 <= tag_s2;
		sum_s3 <= SumW'(px_s2) + SumW'(py_s2) + SumW'(pz_s2) + RoundBias;

		tag_s4  <= tag_s3;
		dist_s4 <= sat_dist;
	end

	assign out_valid = valid_s4;
	assign out_tag   = tag_s4;
	assign distance  = dist_s4;

endmodule

// File: hdl/point_polytope_penetration.sv
// ----------------------------------------------------------------------------
// point_polytope_penetration
// Convex polytope half-space test with penetration depth. Faces sit in a
// ring of cells that rotates once per query past a shared distance pipeline.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+-------------------
//   request  | req_type face_slot normal_x/y/z point_x/y/z  | start & !busy
//   result   | reply_kind hit depth best_face               | done, one cycle
//   config   | psel penable pwrite paddr pwdata prdata      | APB, pready high
//
// A face write is acknowledged in the cycle after its beat; busy stays low.
// A query holds busy for one full ring rotation plus the four-stage
// distance pipeline and a finishing step; its result beat comes in the
// first cycle in which busy is low again.
// Reset clears control and the registers; the face ring is not cleared.
// The result side cannot stall: every beat is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module point_polytope_penetration #(
	parameter int MaxFaces = ppp_pkg::MaxFacesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [5:0]         face_slot,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               done,
	output logic               reply_kind,
	output logic               hit,
	output logic signed [31:0] depth,
	output logic [5:0]         best_face,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import ppp_pkg::*;

	localparam int IdxW = $clog2(MaxFaces);
	localparam int CntW = $clog2(MaxFaces + 1);
	localparam int RunW = $clog2(MaxFaces + DistLat + 1);
	localparam logic [RunW-1:0] ShiftEnd = RunW'(MaxFaces);
	localparam logic [RunW-1:0] RunEnd   = RunW'(MaxFaces + DistLat);

	state_t state_q, state_d;

	logic signed [31:0] margin_q;
	logic [6:0]         face_count_q;
	logic               cfg_wr;

	logic               accept;
	logic               wr_fire;
	logic               query_fire;
	logic               shift;
	logic               feed;
	logic               finish;

	logic [RunW-1:0]    run_cnt_q;
	logic [CntW-1:0]    cnt_q;
	logic [CntW-1:0]    cnt_clamp;
	logic               depth_mode_q;
	logic signed [31:0] lim_q;
	point_t             point_q;

	face_t              wface;
	face_t              cell_face [MaxFaces];

	logic               dist_valid;
	logic [IdxW-1:0]    dist_tag;
	logic signed [31:0] face_dist;

	logic               miss_q;
	logic               found_q;
	logic signed [31:0] best_q;
	logic [IdxW-1:0]    best_idx_q;

	logic               done_q;
	logic               reply_kind_q;
	logic               hit_q;
	logic signed [31:0] depth_q;
	logic [5:0]         best_face_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q     <= MarginRst;
			face_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				RegMargin: margin_q     <= pwdata;
				RegCount:  face_count_q <= pwdata[6:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			RegMargin: prdata = margin_q;
			RegCount:  prdata = {25'd0, face_count_q};
			default:   prdata = '0;
		endcase
	end

	// ---------------- control ----------------
	assign accept     = start & ~busy;
	assign wr_fire    = accept & (req_type == ReqWrite);
	assign query_fire = accept & (req_type != ReqWrite);

	always_comb begin
		if (int'(face_count_q) > MaxFaces) begin
			cnt_clamp = CntW'(MaxFaces);
		end else begin
			cnt_clamp = CntW'(face_count_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			StIdle:  if (query_fire) state_d = StRun;
			StRun:   if (run_cnt_q == RunEnd) state_d = StIdle;
			default: state_d = StIdle;
		endcase
	end

	always_comb begin
		busy   = 1'b0;
		shift  = 1'b0;
		feed   = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			StIdle: ;
			StRun: begin
				busy   = 1'b1;
				shift  = run_cnt_q < ShiftEnd;
				feed   = (run_cnt_q < ShiftEnd) && (run_cnt_q < RunW'(cnt_q));
				finish = run_cnt_q == RunEnd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			run_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (query_fire) begin
				run_cnt_q <= '0;
			end else if (busy) begin
				run_cnt_q <= run_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			cnt_q        <= cnt_clamp;
			depth_mode_q <= req_type == ReqDepth;
			lim_q        <= (req_type == ReqInZero) ? 32'sd0 : margin_q;
			point_q      <= '{x: point_x, y: point_y, z: point_z};
		end
	end

	// ---------------- face ring ----------------
	assign wface = '{nx: normal_x, ny: normal_y, nz: normal_z,
	                 vx: point_x, vy: point_y, vz: point_z};

	for (genvar i = 0; i < MaxFaces; i++) begin : g_ring
		cell_ctrl_t ctrl;

		assign ctrl.we    = wr_fire && (int'(face_slot) == i);
		assign ctrl.shift = shift;

		ppp_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.wdata (wface),
			.nbr   (cell_face[(i + 1) % MaxFaces]),
			.face  (cell_face[i])
		);
	end

	ppp_dist #(
		.IdxW (IdxW)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (feed),
		.in_tag    (run_cnt_q[IdxW-1:0]),
		.face      (cell_face[0]),
		.point     (point_q),
		.out_valid (dist_valid),
		.out_tag   (dist_tag),
		.distance  (face_dist)
	);

	// ---------------- running best and miss ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (query_fire) begin
			miss_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (dist_valid) begin
			if (face_dist > lim_q) begin
				miss_q <= 1'b1;
			end else if (!found_q || face_dist > best_q) begin
				found_q <= 1'b1;
			end
		end
	end

	// first face wins ties: replace only on a strictly larger distance
	always_ff @(posedge clk) begin
		if (dist_valid && !(face_dist > lim_q) && (!found_q || face_dist > best_q)) begin
			best_q     <= face_dist;
			best_idx_q <= dist_tag;
		end
	end

	// ---------------- result beat ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= 1'b0;
			reply_kind_q <= ReplyAck;
			hit_q        <= 1'b0;
			depth_q      <= '0;
			best_face_q  <= '0;
		end else begin
			done_q <= wr_fire | finish;
			if (wr_fire) begin
				reply_kind_q <= ReplyAck;
				hit_q        <= 1'b0;
				depth_q      <= '0;
				best_face_q  <= '0;
			end else if (finish) begin
				reply_kind_q <= ReplyQuery;
				if (depth_mode_q) begin
					hit_q       <= !miss_q && found_q;
					depth_q     <= (!miss_q && found_q) ? best_q : 32'sd0;
					best_face_q <= (!miss_q && found_q) ? 6'(best_idx_q) : 6'd0;
				end else begin
					hit_q       <= !miss_q;
					depth_q     <= '0;
					best_face_q <= '0;
				end
			end
		end
	end

	assign done       = done_q;
	assign reply_kind = reply_kind_q;
	assign hit        = hit_q;
	assign depth      = depth_q;
	assign best_face  = best_face_q;

`ifndef SYNTHESIS
	a_query_ends_in_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done && reply_kind == ReplyQuery))
		else $error("query finished without a result beat");

	a_write_acked: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == ReqWrite) |=> (done && reply_kind == ReplyAck))
		else $error("face write not acknowledged");

	a_ack_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && reply_kind == ReplyAck) |-> (!hit && depth == 32'sd0 && best_face == 6'd0))
		else $error("face write acknowledge carries data");

	a_dist_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid |-> (state_q == StRun))
		else $error("distance beat outside a query");

	a_shift_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		shift |-> !wr_fire)
		else $error("ring shift collides with a face write");
`endif

endmodule
